// ===== design/orb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_pkg: shared types and codes of the overwriting ring buffer
// Request kinds, status codes and the control bundle that the top level
// broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package orb_pkg;

	// Request kinds.
	localparam logic [1:0] REQ_PUSH  = 2'd0;
	localparam logic [1:0] REQ_POP   = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;
	localparam logic [1:0] ST_OVERWRITE = 2'd3;

	// Control broadcast to every cell in a cycle.
	typedef struct packed {
		logic shift;  // each cell takes its upper neighbor's entry; on a push the last takes the push
		logic load;   // a push writes its value into the selected cell
		logic scan;   // the read bus moves one cell toward the front
	} cell_ctl_t;

endpackage

// ===== design/overwriting_ring_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_ring_buffer: ring buffer that overwrites its oldest entry
// Fixed-depth buffer of DEPTH entries kept in a chain of cells in age order.
// ----------------------------------------------------------------------------
// Usage:
// A request (req_type, push_value, position) is taken when in_valid is high
// and in_stall is low. Each request gives one result (read_data, status,
// count, is_full, is_empty, front_data, back_data), offered on out_valid and
// held until out_stall is low.
// Entries sit in the chain with the oldest in cell zero. A push writes the
// cell at the current count, or shifts the whole chain and writes the last
// cell when full. A pop hands the front entry out and shifts the chain.
// A push, pop, clear or out-of-range read goes from idle to the form state,
// where its result goes into the output register once that is free; the
// input stalls until the block is idle again. A read in range at position p
// sends the entry down the read bus one cell per cycle, from cell p to
// cell zero. A new request is taken while an earlier result waits in the
// output register; its own result waits until the receiver takes the older
// one, and the input stalls meanwhile.
// Reset empties the buffer and drops any pending result; the cell contents
// need no clearing since only held entries are ever read.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] push_value,
	input  logic [3:0]         position,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] read_data,
	output logic [1:0]         status,
	output logic [4:0]         count,
	output logic               is_full,
	output logic               is_empty,
	output logic signed [31:0] front_data,
	output logic signed [31:0] back_data
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
	localparam int EXT_W = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FORM = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [DATA_WIDTH-1:0] back_q;
	logic [DATA_WIDTH-1:0] rdata_q;
	logic [1:0]            status_q;
	logic                  is_read_q;
	logic [3:0]            pos_q;
	logic [3:0]            scan_cnt_q;

	logic                  out_valid_q;
	logic signed [31:0]    read_data_q;
	logic [1:0]            status_out_q;
	logic [4:0]            count_out_q;
	logic                  full_out_q;
	logic                  empty_out_q;
	logic signed [31:0]    front_q;
	logic signed [31:0]    back_out_q;

	logic                  accept;
	logic                  full;
	logic                  empty;
	logic                  in_range;
	logic                  out_free;
	logic [CNT_W-1:0]      sel;
	logic signed [EXT_W-1:0] push_ext;
	logic [DATA_WIDTH-1:0] push_data;
	orb_pkg::cell_ctl_t    ctl;

	logic [DATA_WIDTH-1:0] data_w [DEPTH+1];
	logic [DATA_WIDTH-1:0] bus_w  [DEPTH+1];

	// Sign-extend a stored entry from DATA_WIDTH and keep its low 32 bits.
	function automatic logic signed [31:0] to_out(input logic [DATA_WIDTH-1:0] v);
		logic signed [EXT_W-1:0] ext;
		ext = EXT_W'($signed(v));
		return ext[31:0];
	endfunction

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign in_range = (CMP_W'(position) < CMP_W'(count_q));
	assign out_free = !out_valid_q || !out_stall;

	assign push_ext  = EXT_W'(push_value);
	assign push_data = push_ext[DATA_WIDTH-1:0];

	// Cells are selected by the tail index for a push, by the position while
	// the read bus runs.
	assign sel = (state_q == S_SCAN) ? CNT_W'(pos_q) : count_q;

	// Control broadcast to the chain.
	always_comb begin
		ctl.shift = accept && (((req_type == orb_pkg::REQ_PUSH) && full)
			|| ((req_type == orb_pkg::REQ_POP) && !empty));
		ctl.load  = accept && (req_type == orb_pkg::REQ_PUSH);
		ctl.scan  = (state_q == S_SCAN);
	end

	// The chain of cells, oldest entry in cell zero.
	assign data_w[DEPTH] = '0;
	assign bus_w[DEPTH]  = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		orb_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.CNT_W     (CNT_W),
			.INDEX     (i),
			.LAST      (i == DEPTH - 1)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.sel      (sel),
			.push_data(push_data),
			.next_data(data_w[i+1]),
			.next_bus (bus_w[i+1]),
			.data_q   (data_w[i]),
			.bus_q    (bus_w[i])
		);
	end

	// Sequencer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			scan_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req_type)
							orb_pkg::REQ_PUSH: begin
								state_q <= S_FORM;
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							orb_pkg::REQ_POP: begin
								state_q <= S_FORM;
								if (!empty) begin
									count_q <= count_q - CNT_W'(1);
								end
							end
							orb_pkg::REQ_READ: begin
								scan_cnt_q <= '0;
								state_q    <= in_range ? S_SCAN : S_FORM;
							end
							default: begin
								state_q <= S_FORM;
								count_q <= '0;
							end
						endcase
					end
				end
				S_SCAN: begin
					scan_cnt_q <= scan_cnt_q + 4'd1;
					if (scan_cnt_q == pos_q) begin
						state_q <= S_FORM;
					end
				end
				S_FORM: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-request payload captured at acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q     <= position;
			is_read_q <= (req_type == orb_pkg::REQ_READ);
			case (req_type)
				orb_pkg::REQ_PUSH: begin
					back_q   <= push_data;
					rdata_q  <= '0;
					status_q <= full ? orb_pkg::ST_OVERWRITE : orb_pkg::ST_OK;
				end
				orb_pkg::REQ_POP: begin
					if (empty) begin
						rdata_q  <= '0;
						status_q <= orb_pkg::ST_EMPTY;
					end else begin
						rdata_q  <= data_w[0];
						status_q <= orb_pkg::ST_OK;
					end
				end
				orb_pkg::REQ_READ: begin
					rdata_q  <= '0;
					status_q <= in_range ? orb_pkg::ST_OK : orb_pkg::ST_RANGE;
				end
				default: begin
					rdata_q  <= '0;
					status_q <= orb_pkg::ST_OK;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_FORM) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload, formed from the settled chain.
	always_ff @(posedge clk) begin
		if ((state_q == S_FORM) && out_free) begin
			if (is_read_q && (status_q == orb_pkg::ST_OK)) begin
				read_data_q <= to_out(bus_w[0]);
			end else begin
				read_data_q <= to_out(rdata_q);
			end
			status_out_q <= status_q;
			count_out_q  <= 5'(count_q);
			full_out_q   <= full;
			empty_out_q  <= empty;
			front_q      <= empty ? 32'sd0 : to_out(data_w[0]);
			back_out_q   <= empty ? 32'sd0 : to_out(back_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign read_data  = read_data_q;
	assign status     = status_out_q;
	assign count      = count_out_q;
	assign is_full    = full_out_q;
	assign is_empty   = empty_out_q;
	assign front_data = front_q;
	assign back_data  = back_out_q;

endmodule

// ===== design/orb_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_cell: one entry of the ring buffer chain
// Holds the entry at a fixed distance from the front. Entries move one cell
// toward the front on a pop or an overwriting push, and a read value travels
// down a registered bus from the selected cell to cell zero.
// ----------------------------------------------------------------------------
module orb_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 5,
	parameter int INDEX      = 0,
	parameter bit LAST       = 1'b0
) (
	input  logic                  clk,
	input  orb_pkg::cell_ctl_t    ctl,
	input  logic [CNT_W-1:0]      sel,
	input  logic [DATA_WIDTH-1:0] push_data,
	input  logic [DATA_WIDTH-1:0] next_data,
	input  logic [DATA_WIDTH-1:0] next_bus,
	output logic [DATA_WIDTH-1:0] data_q,
	output logic [DATA_WIDTH-1:0] bus_q
);

	logic hit;

	assign hit = (sel == CNT_W'(INDEX));

	// Entry register: a push lands at the tail, which is the last cell when
	// the chain shifts and the selected cell otherwise.
	always_ff @(posedge clk) begin
		if (ctl.load && (ctl.shift ? LAST : hit)) begin
			data_q <= push_data;
		end else if (ctl.shift) begin
			data_q <= next_data;
		end
	end

	// Read bus: the selected cell drops its entry on the bus, the others
	// pass on what the cell above them held.
	always_ff @(posedge clk) begin
		if (ctl.scan) begin
			bus_q <= hit ? data_q : next_bus;
		end
	end

endmodule

// ===== tb/sv/overwriting_ring_buffer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_tb: self-checking bench for the overwriting ring buffer
// Drives push, pop, indexed read and clear requests through the valid/stall
// request channel and checks every result against a behavioral ring model
// that tracks its own store, head pointer and fill level. A directed part
// hits the empty, full, overwrite and out-of-range cases; random traffic
// then runs under several sender idle and receiver stall mixes, plus one
// long receiver hold-off that makes the block back up and stall its input.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer_tb;

	localparam int CLK_PERIOD  = 20;
	localparam int RING_DEPTH  = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_ITEMS = 360;
	localparam int EXP_SLOTS   = 64;

	typedef struct packed {
		logic signed [31:0] rdata;
		logic [1:0]         st;
		logic [4:0]         cnt;
		logic               full;
		logic               empty;
		logic signed [31:0] front;
		logic signed [31:0] back;
	} ring_result_t;

	typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN} traffic_mix_t;

	logic               clk;
	logic               arst_n     = 1'b0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic [1:0]         req_type   = orb_pkg::REQ_PUSH;
	logic signed [31:0] push_value = '0;
	logic [3:0]         position   = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic signed [31:0] read_data;
	logic [1:0]         status;
	logic [4:0]         count;
	logic               is_full;
	logic               is_empty;
	logic signed [31:0] front_data;
	logic signed [31:0] back_data;

	// Model state of the ring.
	logic signed [31:0] ring_store [RING_DEPTH];
	logic [3:0]         ring_head = '0;
	int                 ring_fill = 0;

	// Predicted results in request order; written by the sender, read by the checker.
	ring_result_t exp_buf [EXP_SLOTS];
	int           exp_wr         = 0;
	int           exp_rd         = 0;
	int           err_cnt        = 0;
	int           cycle_cnt      = 0;
	int           send_idle_pct  = 0;
	int           recv_stall_pct = 0;
	int           hold_left      = 0;

	overwriting_ring_buffer #(
		.DEPTH      (RING_DEPTH),
		.DATA_WIDTH (32)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.push_value (push_value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_data  (read_data),
		.status     (status),
		.count      (count),
		.is_full    (is_full),
		.is_empty   (is_empty),
		.front_data (front_data),
		.back_data  (back_data)
	);

	// Clock generation.
	always begin
		clk = 1'b1;
		#(CLK_PERIOD / 2);
		clk = 1'b0;
		#(CLK_PERIOD / 2);
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Long receiver hold-off, counted down in cycles.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Receiver stall: random per cycle, forced high during a hold-off.
	always @(posedge clk) begin
		out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
	end

	// Entry at a given offset from the oldest one.
	function automatic logic signed [31:0] slot_at(int offset);
		return ring_store[(ring_head + offset) % RING_DEPTH];
	endfunction

	// Applies one request to the model ring and returns the result it gives.
	function automatic ring_result_t predict_ring_result(logic [1:0] kind,
			logic signed [31:0] value, logic [3:0] pos);
		ring_result_t r;
		r = '0;
		r.st = orb_pkg::ST_OK;
		case (kind)
			orb_pkg::REQ_PUSH: begin
				if (ring_fill < RING_DEPTH) begin
					ring_store[(ring_head + ring_fill) % RING_DEPTH] = value;
					ring_fill++;
				end else begin
					ring_store[ring_head] = value;
					ring_head = ring_head + 4'd1;
					r.st = orb_pkg::ST_OVERWRITE;
				end
			end
			orb_pkg::REQ_POP: begin
				if (ring_fill == 0) begin
					r.st = orb_pkg::ST_EMPTY;
				end else begin
					r.rdata = slot_at(0);
					ring_head = ring_head + 4'd1;
					ring_fill--;
				end
			end
			orb_pkg::REQ_READ: begin
				if (pos < ring_fill) begin
					r.rdata = slot_at(pos);
				end else begin
					r.st = orb_pkg::ST_RANGE;
				end
			end
			default: begin
				ring_head = '0;
				ring_fill = 0;
			end
		endcase
		r.cnt   = ring_fill[4:0];
		r.full  = (ring_fill == RING_DEPTH);
		r.empty = (ring_fill == 0);
		if (ring_fill != 0) begin
			r.front = slot_at(0);
			r.back  = slot_at(ring_fill - 1);
		end
		return r;
	endfunction

	// Offers one request, waits until it is taken, and records its result.
	task automatic send_req(logic [1:0] kind, logic signed [31:0] value, logic [3:0] pos);
		ring_result_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		push_value <= value;
		position   <= pos;
		do @(posedge clk); while (in_stall);
		want = predict_ring_result(kind, value, pos);
		exp_buf[exp_wr % EXP_SLOTS] = want;
		exp_wr++;
	endtask

	// Drops the request valid and waits for every outstanding result.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (exp_wr != exp_rd) begin
			@(posedge clk);
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
			err_cnt++;
		end
	endtask

	// Compares each taken result with the oldest outstanding prediction.
	always @(posedge clk) begin : result_check
		ring_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (exp_wr == exp_rd) begin
				$display("%0t: unexpected result: expected none, actual status %0d data %0h",
					$time, status, read_data);
				err_cnt++;
			end else begin
				want = exp_buf[exp_rd % EXP_SLOTS];
				exp_rd++;
				check_field("read_data", want.rdata, read_data);
				check_field("status", want.st, status);
				check_field("count", want.cnt, count);
				check_field("is_full", want.full, is_full);
				check_field("is_empty", want.empty, is_empty);
				check_field("front_data", want.front, front_data);
				check_field("back_data", want.back, back_data);
			end
		end
	end

	// Pop, read and clear on an empty buffer.
	task automatic test_empty_requests();
		send_req(orb_pkg::REQ_POP, 32'sd0, 4'd0);
		send_req(orb_pkg::REQ_READ, 32'sd0, 4'd0);
		send_req(orb_pkg::REQ_CLEAR, 32'sd0, 4'd0);
		wait_drained();
	endtask

	// Fill to the brim, starting with corner values, then push once more to overwrite.
	task automatic test_fill_and_overwrite();
		logic signed [31:0] corner_vals [4];
		corner_vals = '{32'sh7fffffff, 32'sh80000000, 32'sh00000000, 32'shffffffff};
		for (int i = 0; i < RING_DEPTH; i++) begin
			send_req(orb_pkg::REQ_PUSH, (i < 4) ? corner_vals[i] : $urandom, 4'd0);
		end
		send_req(orb_pkg::REQ_PUSH, 32'sh5a5a5a5a, 4'd0);
		wait_drained();
	endtask

	// Reads at both ends of a full buffer, a pop, a read past the end, a clear.
	task automatic test_reads_and_pop();
		send_req(orb_pkg::REQ_READ, 32'sd0, 4'd15);
		send_req(orb_pkg::REQ_READ, 32'sd0, 4'd0);
		send_req(orb_pkg::REQ_POP, 32'sd0, 4'd0);
		send_req(orb_pkg::REQ_READ, 32'sd0, 4'd15);
		send_req(orb_pkg::REQ_CLEAR, 32'sd0, 4'd0);
		wait_drained();
	endtask

	// Picks one random request, biased by the current traffic mix.
	task automatic send_random_req(traffic_mix_t mix);
		int          roll;
		int          push_cut;
		int          pop_cut;
		logic [1:0]  kind;
		logic [31:0] value;
		logic [3:0]  pos;
		case (mix)
			MIX_FILL:  begin push_cut = 70; pop_cut = 80; end
			MIX_DRAIN: begin push_cut = 25; pop_cut = 70; end
			default:   begin push_cut = 40; pop_cut = 65; end
		endcase
		roll = $urandom_range(99);
		if (roll < push_cut) begin
			kind = orb_pkg::REQ_PUSH;
		end else if (roll < pop_cut) begin
			kind = orb_pkg::REQ_POP;
		end else if (roll < 97) begin
			kind = orb_pkg::REQ_READ;
		end else begin
			kind = orb_pkg::REQ_CLEAR;
		end
		// Occasionally push a corner value instead of a random word.
		case ($urandom_range(15))
			0:       value = 32'h7fffffff;
			1:       value = 32'h80000000;
			2:       value = 32'hffffffff;
			3:       value = 32'h00000000;
			default: value = $urandom;
		endcase
		// Mostly read held entries, sometimes any position.
		if (ring_fill > 0 && $urandom_range(3) != 0) begin
			pos = 4'($urandom_range(ring_fill - 1));
		end else begin
			pos = 4'($urandom_range(15));
		end
		send_req(kind, value, pos);
	endtask

	// Random traffic in bursts of changing mix under one idling setting.
	task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
		traffic_mix_t mix;
		mix = MIX_BALANCED;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int i = 0; i < n_items; i++) begin
			if (i % 24 == 0) begin
				mix = traffic_mix_t'($urandom_range(2));
			end
			send_random_req(mix);
		end
		wait_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	// Receiver holds off for a long stretch while requests keep coming.
	task automatic test_backpressure_fill();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left <= HOLD_CYCLES;
		for (int i = 0; i < 40; i++) begin
			send_random_req(MIX_FILL);
		end
		wait_drained();
	endtask

	// Test sequence.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_requests();
		test_fill_and_overwrite();
		test_reads_and_pop();
		test_random_traffic(PHASE_ITEMS, 0, 0);
		test_backpressure_fill();
		test_random_traffic(PHASE_ITEMS, 60, 0);
		test_random_traffic(PHASE_ITEMS, 0, 60);
		test_random_traffic(PHASE_ITEMS, 36, 36);

		wait_drained();
		repeat (30) @(posedge clk);
		if (err_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
